FILE: rtl/jbt_pkg.sv
// jbt_pkg: types, codes, constants and helper functions for the JSON byte
// tokenizer. Used by jbt_lexer, jbt_result_fifo and json_byte_tokenizer_unit.
// No dependencies.
package jbt_pkg;

  localparam int POSITION_BITS     = 16;
  localparam int RESULT_FIFO_DEPTH = 4;  // power of two, at least 2
  localparam int FIFO_IDX_W        = $clog2(RESULT_FIFO_DEPTH);
  localparam int FIFO_CNT_W        = $clog2(RESULT_FIFO_DEPTH + 1);
  localparam int WORD_LEN_W        = 3;

  typedef logic [POSITION_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};
  localparam pos_t POS_ONE = pos_t'(1);

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic ERR_UNTERMINATED = 1'b0;
  localparam logic ERR_KEYWORD      = 1'b1;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_TOKEN = 2'd1,
    EV_ERROR = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    TK_EOF    = 3'd0,  // also an unresolved word byte
    TK_NUMBER = 3'd1,
    TK_STRING = 3'd2,
    TK_NULL   = 3'd3,
    TK_TRUE   = 3'd4,
    TK_FALSE  = 3'd5,
    TK_PUNCT  = 3'd6
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_STRING = 2'd2,
    MODE_WORD   = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    token_kind_t token_kind;
    logic [7:0]  payload_byte;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        error_code;
    logic        last_of_item;
  } out_item_t;

  // results of one transfer: 0, 1 or 2 of them
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } result_pair_t;

  typedef struct packed {
    pos_t line;
    pos_t column;
  } position_t;

  function automatic logic is_space_byte(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF ||
           c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic position_t advance(input pos_t line, input pos_t column,
                                        input logic [7:0] c);
    position_t p;
    p.line   = line;
    p.column = column;
    if (c == CH_LF) begin
      if (line != POS_MAX) p.line = line + POS_ONE;
      p.column = POS_ONE;
    end else if (column != POS_MAX) begin
      p.column = column + POS_ONE;
    end
    return p;
  endfunction

  // keyword table: 0 null, 1 true, 2 false
  function automatic logic [7:0] kw_char(input logic [1:0] k,
                                         input logic [WORD_LEN_W-1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      2'd0: begin
        case (idx)
          3'd0: ch = 8'h6E; 3'd1: ch = 8'h75; 3'd2: ch = 8'h6C; 3'd3: ch = 8'h6C;
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0: ch = 8'h74; 3'd1: ch = 8'h72; 3'd2: ch = 8'h75; 3'd3: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0: ch = 8'h66; 3'd1: ch = 8'h61; 3'd2: ch = 8'h6C; 3'd3: ch = 8'h73;
          3'd4: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [WORD_LEN_W-1:0] kw_len(input logic [1:0] k);
    logic [WORD_LEN_W-1:0] len;
    case (k)
      2'd0:    len = 3'd4;
      2'd1:    len = 3'd4;
      2'd2:    len = 3'd5;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] word_flags_next(input logic [2:0] flags,
                                                 input logic [WORD_LEN_W-1:0] len,
                                                 input logic [7:0] c);
    logic [2:0] alive;
    for (int k = 0; k < 3; k++) begin
      alive[k] = flags[k] && (len < kw_len(2'(k))) && (kw_char(2'(k), len) == c);
    end
    return alive;
  endfunction

  function automatic out_item_t make_result(input event_kind_t ev,
                                            input token_kind_t kind,
                                            input logic [7:0] pay,
                                            input pos_t line,
                                            input pos_t column);
    out_item_t r;
    r.event_kind   = ev;
    r.token_kind   = kind;
    r.payload_byte = pay;
    r.start_line   = 16'(line);
    r.start_column = 16'(column);
    r.error_code   = ERR_UNTERMINATED;
    r.last_of_item = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/jbt_lexer.sv
// jbt_lexer: scanner state and the single-pass step logic of the tokenizer.
// Produces up to two results per accepted byte. Depends on jbt_pkg.
module jbt_lexer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  jbt_pkg::in_item_t    item,
  output jbt_pkg::result_pair_t results
);

  jbt_pkg::scan_mode_t            mode, mode_next;
  logic                           escape_pending, escape_pending_next;
  logic [2:0]                     word_flags, word_flags_next;
  logic [jbt_pkg::WORD_LEN_W-1:0] word_length, word_length_next;
  jbt_pkg::pos_t                  line_count, line_count_next;
  jbt_pkg::pos_t                  column_count, column_count_next;
  jbt_pkg::pos_t                  start_line, start_line_next;
  jbt_pkg::pos_t                  start_column, start_column_next;
  logic                           halted, halted_next;

  logic                 eot;
  logic [7:0]           c;
  logic                 to_idle;
  logic                 idle_has;
  jbt_pkg::out_item_t   idle_res;
  jbt_pkg::position_t   adv;
  jbt_pkg::token_kind_t word_kind;
  jbt_pkg::result_pair_t step;

  always_comb begin
    mode_next           = mode;
    escape_pending_next = escape_pending;
    word_flags_next     = word_flags;
    word_length_next    = word_length;
    line_count_next     = line_count;
    column_count_next   = column_count;
    start_line_next     = start_line;
    start_column_next   = start_column;
    halted_next         = halted;
    step                = '0;
    to_idle             = 1'b0;
    idle_has            = 1'b0;
    idle_res            = '0;
    word_kind           = jbt_pkg::TK_EOF;
    eot                 = item.end_of_text;
    c                   = item.text_byte;
    adv                 = jbt_pkg::advance(line_count, column_count, c);

    for (int k = 0; k < 3; k++) begin
      if (word_flags[k] && word_length == jbt_pkg::kw_len(2'(k))) begin
        word_kind = jbt_pkg::token_kind_t'(3'(3 + k));
      end
    end

    if (!halted) begin
      case (mode)
        jbt_pkg::MODE_NUMBER: begin
          step.count = 2'd1;
          if (!eot && (jbt_pkg::is_numeral(c) || c == jbt_pkg::CH_DOT)) begin
            step.first = jbt_pkg::make_result(jbt_pkg::EV_BYTE, jbt_pkg::TK_NUMBER, c,
                                              start_line, start_column);
            line_count_next   = adv.line;
            column_count_next = adv.column;
          end else begin
            step.first = jbt_pkg::make_result(jbt_pkg::EV_TOKEN, jbt_pkg::TK_NUMBER,
                                              8'h00, start_line, start_column);
            mode_next = jbt_pkg::MODE_IDLE;
            to_idle   = 1'b1;
          end
        end
        jbt_pkg::MODE_STRING: begin
          if (eot) begin
            step.count = 2'd1;
            step.first = jbt_pkg::make_result(jbt_pkg::EV_ERROR, jbt_pkg::TK_EOF, 8'h00,
                                              start_line, start_column);
            step.first.error_code = jbt_pkg::ERR_UNTERMINATED;
            halted_next = 1'b1;
            mode_next   = jbt_pkg::MODE_IDLE;
          end else if (escape_pending) begin
            escape_pending_next = 1'b0;
            step.count = 2'd1;
            step.first = jbt_pkg::make_result(jbt_pkg::EV_BYTE, jbt_pkg::TK_STRING, c,
                                              start_line, start_column);
            line_count_next   = adv.line;
            column_count_next = adv.column;
          end else if (c == jbt_pkg::CH_BSLASH) begin
            escape_pending_next = 1'b1;
            line_count_next     = adv.line;
            column_count_next   = adv.column;
          end else if (c == jbt_pkg::CH_QUOTE) begin
            step.count = 2'd1;
            step.first = jbt_pkg::make_result(jbt_pkg::EV_TOKEN, jbt_pkg::TK_STRING,
                                              8'h00, start_line, start_column);
            mode_next         = jbt_pkg::MODE_IDLE;
            line_count_next   = adv.line;
            column_count_next = adv.column;
          end else begin
            step.count = 2'd1;
            step.first = jbt_pkg::make_result(jbt_pkg::EV_BYTE, jbt_pkg::TK_STRING, c,
                                              start_line, start_column);
            line_count_next   = adv.line;
            column_count_next = adv.column;
          end
        end
        jbt_pkg::MODE_WORD: begin
          step.count = 2'd1;
          if (!eot && jbt_pkg::is_alpha(c)) begin
            word_flags_next = jbt_pkg::word_flags_next(word_flags, word_length, c);
            if (word_length != {jbt_pkg::WORD_LEN_W{1'b1}}) begin
              word_length_next = word_length + jbt_pkg::WORD_LEN_W'(1);
            end
            step.first = jbt_pkg::make_result(jbt_pkg::EV_BYTE, jbt_pkg::TK_EOF, c,
                                              start_line, start_column);
            line_count_next   = adv.line;
            column_count_next = adv.column;
          end else begin
            mode_next = jbt_pkg::MODE_IDLE;
            if (word_kind == jbt_pkg::TK_EOF) begin
              step.first = jbt_pkg::make_result(jbt_pkg::EV_ERROR, jbt_pkg::TK_EOF, 8'h00,
                                                start_line, start_column);
              step.first.error_code = jbt_pkg::ERR_KEYWORD;
              halted_next = 1'b1;
            end else begin
              step.first = jbt_pkg::make_result(jbt_pkg::EV_TOKEN, word_kind, 8'h00,
                                                start_line, start_column);
              to_idle = 1'b1;
            end
          end
        end
        jbt_pkg::MODE_IDLE: to_idle = 1'b1;
        default:            to_idle = 1'b1;
      endcase

      if (to_idle) begin
        if (eot) begin
          idle_has = 1'b1;
          idle_res = jbt_pkg::make_result(jbt_pkg::EV_TOKEN, jbt_pkg::TK_EOF, 8'h00,
                                          line_count, column_count);
        end else begin
          line_count_next   = adv.line;
          column_count_next = adv.column;
          if (jbt_pkg::is_space_byte(c)) begin
            idle_has = 1'b0;
          end else if (jbt_pkg::is_numeral(c) || c == jbt_pkg::CH_MINUS) begin
            start_line_next   = line_count;
            start_column_next = column_count;
            mode_next         = jbt_pkg::MODE_NUMBER;
            idle_has          = 1'b1;
            idle_res = jbt_pkg::make_result(jbt_pkg::EV_BYTE, jbt_pkg::TK_NUMBER, c,
                                            line_count, column_count);
          end else if (c == jbt_pkg::CH_QUOTE) begin
            start_line_next     = line_count;
            start_column_next   = column_count;
            mode_next           = jbt_pkg::MODE_STRING;
            escape_pending_next = 1'b0;
          end else if (jbt_pkg::is_alpha(c)) begin
            start_line_next   = line_count;
            start_column_next = column_count;
            mode_next         = jbt_pkg::MODE_WORD;
            word_flags_next   = jbt_pkg::word_flags_next(3'b111, '0, c);
            word_length_next  = jbt_pkg::WORD_LEN_W'(1);
            idle_has          = 1'b1;
            idle_res = jbt_pkg::make_result(jbt_pkg::EV_BYTE, jbt_pkg::TK_EOF, c,
                                            line_count, column_count);
          end else begin
            idle_has = 1'b1;
            idle_res = jbt_pkg::make_result(jbt_pkg::EV_TOKEN, jbt_pkg::TK_PUNCT, c,
                                            line_count, column_count);
          end
        end
        if (idle_has) begin
          if (step.count == 2'd0) begin
            step.first = idle_res;
            step.count = 2'd1;
          end else begin
            step.second = idle_res;
            step.count  = 2'd2;
          end
        end
      end

      if (step.count == 2'd1) step.first.last_of_item = 1'b1;
      if (step.count == 2'd2) step.second.last_of_item = 1'b1;
    end
  end

  assign results = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= jbt_pkg::MODE_IDLE;
      escape_pending <= 1'b0;
      word_flags     <= 3'b111;
      word_length    <= '0;
      line_count     <= jbt_pkg::POS_ONE;
      column_count   <= jbt_pkg::POS_ONE;
      start_line     <= jbt_pkg::POS_ONE;
      start_column   <= jbt_pkg::POS_ONE;
      halted         <= 1'b0;
    end else if (take) begin
      mode           <= mode_next;
      escape_pending <= escape_pending_next;
      word_flags     <= word_flags_next;
      word_length    <= word_length_next;
      line_count     <= line_count_next;
      column_count   <= column_count_next;
      start_line     <= start_line_next;
      start_column   <= start_column_next;
      halted         <= halted_next;
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted cleared without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> results.count == 2'd0)
    else $error("results produced while halted");

  a_escape_in_string: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> (mode == jbt_pkg::MODE_STRING || halted))
    else $error("escape pending outside a string");

endmodule

FILE: rtl/jbt_result_fifo.sv
// jbt_result_fifo: small result queue that takes up to two results per cycle
// and hands out one per transfer. Depends on jbt_pkg.
module jbt_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  jbt_pkg::result_pair_t push,
  output logic                  room,
  output logic                  valid,
  input  logic                  stall,
  output jbt_pkg::out_item_t    item
);

  jbt_pkg::out_item_t mem [jbt_pkg::RESULT_FIFO_DEPTH];
  logic [jbt_pkg::FIFO_IDX_W-1:0] head, tail;
  logic [jbt_pkg::FIFO_CNT_W-1:0] count, count_next;
  logic pop;

  assign valid = count != '0;
  assign item  = mem[head];
  assign pop   = valid && !stall;
  assign room  = count <= jbt_pkg::FIFO_CNT_W'(jbt_pkg::RESULT_FIFO_DEPTH - 2);

  assign count_next = count + jbt_pkg::FIFO_CNT_W'(push.count)
                      - jbt_pkg::FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[tail] <= push.first;
    if (push.count == 2'd2) mem[tail + jbt_pkg::FIFO_IDX_W'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + jbt_pkg::FIFO_IDX_W'(push.count);
      if (pop) head <= head + jbt_pkg::FIFO_IDX_W'(1);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |->
      (32'(count) + 32'(push.count) <= 32'(jbt_pkg::RESULT_FIFO_DEPTH)))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= jbt_pkg::FIFO_CNT_W'(jbt_pkg::RESULT_FIFO_DEPTH))
    else $error("result count out of range");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    valid && stall |=> valid && $stable(item))
    else $error("stalled result changed");

endmodule

FILE: rtl/json_byte_tokenizer_unit.sv
// json_byte_tokenizer_unit: streaming JSON tokenizer, one text byte or end
// marker per input transfer. Depends on jbt_pkg, jbt_lexer, jbt_result_fifo.
//
// Each input transfer is scanned in the cycle it is taken and yields zero, one
// or two results (lexeme bytes, finished tokens with kind and start position,
// or an error), which enter a four-entry result queue; last_of_item marks the
// final result of each byte. A byte is taken in any cycle in which the queue
// has room for two results, so with the output side always ready the block
// sustains one byte per cycle for bytes that give at most one result; bytes
// that give two each outpace the one-result-per-cycle queue drain and stall
// input while it drains. After an unterminated string or an unknown word the
// block reports the error and then consumes bytes silently until reset.
module json_byte_tokenizer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  jbt_pkg::in_item_t  byte_item,
  output logic               result_valid,
  input  logic               result_stall,
  output jbt_pkg::out_item_t result_item
);

  logic                  take;
  logic                  room;
  jbt_pkg::result_pair_t step;
  jbt_pkg::result_pair_t push;

  assign byte_stall = !room;
  assign take       = byte_valid && room;

  always_comb begin
    push = step;
    if (!take) push.count = 2'd0;
  end

  jbt_lexer u_lexer (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (byte_item),
    .results (step)
  );

  jbt_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (result_valid),
    .stall (result_stall),
    .item  (result_item)
  );

endmodule
